@@ sv/nfc_type4_tag_ndef_responder_unit_macros.svh @@
// Assertion helpers used by the responder top-level file.
`ifndef NFC_TYPE4_TAG_NDEF_RESPONDER_UNIT_MACROS_SVH
`define NFC_TYPE4_TAG_NDEF_RESPONDER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFCT4_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFCT4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/nfct4_pkg.sv @@
`timescale 1ns / 1ps
package nfct4_pkg;

   localparam int RECORD_DEPTH_DEFAULT = 1024;

   localparam logic [1:0] OP_CMD  = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_ACT  = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [1:0] MODE_READY = 2'd0;
   localparam logic [1:0] MODE_APP   = 2'd1;
   localparam logic [1:0] MODE_CC    = 2'd2;
   localparam logic [1:0] MODE_NDEF  = 2'd3;

   localparam logic CSR_RECORD_SIZE = 1'b0;

   localparam logic [3:0] HDR_LEN = 4'd12;

   localparam logic [95:0] PAT_APP  = 96'h00A4_0400_07D2_7600_0085_0101;
   localparam logic [55:0] PAT_CC   = 56'h00A4_000C_02E1_03;
   localparam logic [55:0] PAT_NDEF = 56'h00A4_000C_02E1_04;
   localparam logic [15:0] PAT_READ = 16'h00B0;
   localparam logic [31:0] PAT_SEL  = 32'h00A4_0400;

   localparam logic [7:0] CC_LEN = 8'd15;

   localparam logic [15:0] SW_OK   = 16'h9000;
   localparam logic [15:0] SW_FAIL = 16'h6A82;

   typedef struct packed {
      logic hdr_write;
      logic activate;
      logic mem_write;
      logic decode_go;
      logic stream_go;
   } ctrl_cmd_type;

   typedef struct packed {
      logic stream_last;
   } dp_status_type;

   function automatic logic [7:0] cc_byte(input logic [3:0] idx);
      logic [7:0] b;
      b = 8'h00;
      unique case (idx)
         4'd0:  b = 8'h00;
         4'd1:  b = 8'h0F;
         4'd2:  b = 8'h20;
         4'd3:  b = 8'h00;
         4'd4:  b = 8'hFF;
         4'd5:  b = 8'h00;
         4'd6:  b = 8'hFF;
         4'd7:  b = 8'h04;
         4'd8:  b = 8'h06;
         4'd9:  b = 8'hE1;
         4'd10: b = 8'h04;
         4'd11: b = 8'h00;
         4'd12: b = 8'hFF;
         4'd13: b = 8'h00;
         4'd14: b = 8'h00;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ sv/nfct4_ctrl.sv @@
`timescale 1ns / 1ps
module nfct4_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_opcode,
   input  logic                     req_last_byte,
   input  nfct4_pkg::dp_status_type status,
   output nfct4_pkg::ctrl_cmd_type  cmd,
   output logic                     busy
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_STREAM = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  nfct4_pkg::OP_CMD: begin
                     cmd.hdr_write = 1'b1;
                     if (req_last_byte) begin
                        state_in = ST_DECODE;
                     end
                  end
                  nfct4_pkg::OP_LOAD: cmd.mem_write = 1'b1;
                  nfct4_pkg::OP_ACT:  cmd.activate  = 1'b1;
                  nfct4_pkg::OP_NONE: ;
                  default: ;
               endcase
            end
         end
         ST_DECODE: begin
            cmd.decode_go = 1'b1;
            state_in      = ST_STREAM;
         end
         ST_STREAM: begin
            cmd.stream_go = 1'b1;
            if (status.stream_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/nfct4_datapath.sv @@
`timescale 1ns / 1ps
module nfct4_datapath #(
   parameter int RECORD_DEPTH = nfct4_pkg::RECORD_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  nfct4_pkg::ctrl_cmd_type  cmd,
   output nfct4_pkg::dp_status_type status,
   input  logic [7:0]               req_data_byte,
   input  logic [9:0]               req_load_address,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     rsp_strobe,
   output logic [63:0]              rsp_resp_bytes,
   output logic [3:0]               rsp_byte_count,
   output logic                     rsp_last_word,
   output logic                     rsp_record_done
);

   localparam int          AW      = $clog2(RECORD_DEPTH);
   localparam logic [16:0] DEPTH_W = 17'(RECORD_DEPTH);

   // Configuration register.
   logic [10:0] size_ff;
   logic [10:0] eff_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (psel && penable && pwrite && (paddr[2] == nfct4_pkg::CSR_RECORD_SIZE)) begin
         size_ff <= pwdata[10:0];
      end
   end

   assign prdata   = (paddr[2] == nfct4_pkg::CSR_RECORD_SIZE) ? {21'd0, size_ff} : 32'd0;
   assign eff_size = (17'(size_ff) > DEPTH_W) ? 11'(RECORD_DEPTH) : size_ff;

   // Command header capture.
   logic [7:0]  hdr_ff [12];
   logic [3:0]  rcvd_ff;
   logic [95:0] hdr_vec;

   always_ff @(posedge clock) begin
      if (reset || cmd.activate || cmd.decode_go) begin
         rcvd_ff <= '0;
         for (int i = 0; i < 12; i++) begin
            hdr_ff[i] <= '0;
         end
      end else if (cmd.hdr_write && (rcvd_ff < nfct4_pkg::HDR_LEN)) begin
         hdr_ff[rcvd_ff] <= req_data_byte;
         rcvd_ff         <= rcvd_ff + 4'd1;
      end
   end

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         hdr_vec[95 - 8*i -: 8] = hdr_ff[i];
      end
   end

   // Command decode.
   logic [1:0]  mode_ff;
   logic        dec_ok, dec_cc, dec_done;
   logic [1:0]  dec_mode;
   logic [7:0]  dec_n;
   logic [15:0] rd_off;
   logic [7:0]  rd_len;
   logic [16:0] rd_end, file_end;

   assign rd_off   = {hdr_ff[2], hdr_ff[3]};
   assign rd_len   = hdr_ff[4];
   assign rd_end   = 17'(rd_off) + 17'(rd_len);
   assign file_end = 17'(eff_size) + 17'd2;

   always_comb begin
      dec_ok   = 1'b0;
      dec_cc   = 1'b0;
      dec_done = 1'b0;
      dec_mode = mode_ff;
      dec_n    = '0;
      priority if (rcvd_ff >= 4'd12 && hdr_vec == nfct4_pkg::PAT_APP) begin
         dec_mode = nfct4_pkg::MODE_APP;
         dec_ok   = 1'b1;
      end else if (rcvd_ff >= 4'd7 && hdr_vec[95:40] == nfct4_pkg::PAT_CC) begin
         if (mode_ff == nfct4_pkg::MODE_APP) begin
            dec_mode = nfct4_pkg::MODE_CC;
            dec_ok   = 1'b1;
         end
      end else if (rcvd_ff >= 4'd7 && hdr_vec[95:40] == nfct4_pkg::PAT_NDEF) begin
         dec_mode = nfct4_pkg::MODE_NDEF;
         dec_ok   = 1'b1;
      end else if (rcvd_ff >= 4'd2 && hdr_vec[95:80] == nfct4_pkg::PAT_READ) begin
         if (mode_ff == nfct4_pkg::MODE_CC) begin
            dec_cc = 1'b1;
            dec_n  = nfct4_pkg::CC_LEN;
            dec_ok = 1'b1;
         end else if (mode_ff == nfct4_pkg::MODE_NDEF && rd_end <= file_end) begin
            dec_n    = rd_len;
            dec_ok   = 1'b1;
            dec_done = (rd_end >= file_end);
         end
      end else if (rcvd_ff >= 4'd4 && hdr_vec[95:64] == nfct4_pkg::PAT_SEL) begin
         dec_ok = 1'b1;
      end else begin
         dec_ok = 1'b0;
      end
   end

   // Response plan, latched at decode.
   logic        ok_ff, cc_ff, done_ff;
   logic [7:0]  n_ff;
   logic [15:0] off_ff;
   logic [8:0]  j_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.activate) begin
         mode_ff <= nfct4_pkg::MODE_READY;
      end else if (cmd.decode_go) begin
         mode_ff <= dec_ok ? dec_mode : nfct4_pkg::MODE_READY;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode_go) begin
         ok_ff   <= dec_ok;
         cc_ff   <= dec_cc;
         done_ff <= dec_ok & dec_done;
         n_ff    <= dec_ok ? dec_n : 8'd0;
         off_ff  <= rd_off;
         j_ff    <= '0;
      end else if (cmd.stream_go) begin
         j_ff <= j_ff + 9'd1;
      end
   end

   assign status.stream_last = (j_ff == ({1'b0, n_ff} + 9'd1));

   // Byte source for the current position.
   logic [16:0]   pos;
   logic [8:0]    sw_idx;
   logic [15:0]   sw_word;
   logic          s1_mem_in;
   logic [7:0]    s1_byte_in;
   logic [AW-1:0] rd_addr;

   assign pos     = 17'(off_ff) + 17'(j_ff);
   assign rd_addr = AW'(pos - 17'd2);
   assign sw_idx  = j_ff - {1'b0, n_ff};
   assign sw_word = ok_ff ? nfct4_pkg::SW_OK : nfct4_pkg::SW_FAIL;

   always_comb begin
      s1_mem_in  = 1'b0;
      s1_byte_in = '0;
      priority if (j_ff < {1'b0, n_ff}) begin
         priority if (cc_ff) begin
            s1_byte_in = nfct4_pkg::cc_byte(j_ff[3:0]);
         end else if (pos == 17'd0) begin
            s1_byte_in = {5'd0, eff_size[10:8]};
         end else if (pos == 17'd1) begin
            s1_byte_in = eff_size[7:0];
         end else begin
            s1_mem_in = 1'b1;
         end
      end else begin
         s1_byte_in = sw_idx[0] ? sw_word[7:0] : sw_word[15:8];
      end
   end

   // Record store: one write and one read per cycle.
   logic [7:0] mem [RECORD_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_write && (17'(req_load_address) < DEPTH_W)) begin
         mem[AW'(req_load_address)] <= req_data_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Stage one: byte in flight.
   logic       s1_valid_ff, s1_mem_ff, s1_final_ff;
   logic [7:0] s1_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.stream_go;
      end
      s1_mem_ff   <= s1_mem_in;
      s1_byte_ff  <= s1_byte_in;
      s1_final_ff <= status.stream_last;
   end

   // Stage two: pack bytes into words, top lane first.
   logic [63:0] word_ff, word_in;
   logic [2:0]  cnt_ff;
   logic [7:0]  byte2;
   logic        emit;
   logic        strobe_ff;
   logic [63:0] resp_bytes_ff;
   logic [3:0]  byte_count_ff;
   logic        last_word_ff, record_done_ff;

   assign byte2 = s1_mem_ff ? rd_data_ff : s1_byte_ff;
   assign emit  = s1_valid_ff & ((cnt_ff == 3'd7) | s1_final_ff);

   always_comb begin
      word_in = word_ff;
      word_in[{3'd7 - cnt_ff, 3'b000} +: 8] = byte2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff        <= '0;
         cnt_ff         <= '0;
         strobe_ff      <= 1'b0;
         resp_bytes_ff  <= '0;
         byte_count_ff  <= '0;
         last_word_ff   <= 1'b0;
         record_done_ff <= 1'b0;
      end else begin
         strobe_ff <= emit;
         if (emit) begin
            resp_bytes_ff  <= word_in;
            byte_count_ff  <= {1'b0, cnt_ff} + 4'd1;
            last_word_ff   <= s1_final_ff;
            record_done_ff <= s1_final_ff & done_ff;
            word_ff        <= '0;
            cnt_ff         <= '0;
         end else begin
            record_done_ff <= 1'b0;
            if (s1_valid_ff) begin
               word_ff <= word_in;
               cnt_ff  <= cnt_ff + 3'd1;
            end
         end
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_resp_bytes  = resp_bytes_ff;
   assign rsp_byte_count  = byte_count_ff;
   assign rsp_last_word   = last_word_ff;
   assign rsp_record_done = record_done_ff;

endmodule

@@ sv/nfc_type4_tag_ndef_responder_unit.sv @@
`timescale 1ns / 1ps
// Channel     Ports                                   Transaction taken when
// input       start, busy, req_*                      start high and busy low
// result      rsp_strobe, rsp_*                       rsp_strobe high (one cycle)
// config      psel, penable, pwrite, paddr, pwdata    psel, penable, pwrite, pready high
//
// A record load, an activation or a command byte that is not the last is taken while busy stays low.
// The last command byte leads through a decode state, a stream state that sends one response
// byte (2 to 257 of them) per cycle, and a flush state.
// Each full word carries eight bytes; the final word of a response
// appears in the cycle after the flush cycle, when busy is already low again.
// Reset is synchronous and active high; the record store holds no reset value.
// The receiver cannot stall: each result is marked by rsp_strobe for one cycle only.
`include "nfc_type4_tag_ndef_responder_unit_macros.svh"
module nfc_type4_tag_ndef_responder_unit #(
   parameter int RECORD_DEPTH = nfct4_pkg::RECORD_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [9:0]  req_load_address,
   // Result channel.
   output logic        rsp_strobe,
   output logic [63:0] rsp_resp_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_word,
   output logic        rsp_record_done,
   // Configuration port; the record length register lies at byte address zero.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // The controller sequences each command transaction: it captures header bytes,
   // triggers the decode of the stored header, then steps the datapath once per
   // response byte. The datapath keeps the selection mode, the header, the record
   // store and a two-stage pipeline that packs bytes into response words.
   nfct4_pkg::ctrl_cmd_type  cmd;
   nfct4_pkg::dp_status_type status;

   assign pready = 1'b1;

   nfct4_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_opcode    (req_opcode),
      .req_last_byte (req_last_byte),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   nfct4_datapath #(
      .RECORD_DEPTH (RECORD_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data_byte    (req_data_byte),
      .req_load_address (req_load_address),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_resp_bytes   (rsp_resp_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_word    (rsp_last_word),
      .rsp_record_done  (rsp_record_done)
   );

   // Conditions named for the checks below.
   logic count_legal, mid_word, full_count, final_word, cmd_end;

   assign count_legal = (rsp_byte_count != 4'd0) && (rsp_byte_count <= 4'd8);
   assign mid_word    = rsp_strobe && !rsp_last_word;
   assign full_count  = (rsp_byte_count == 4'd8);
   assign final_word  = rsp_strobe && rsp_last_word;
   assign cmd_end     = start && !busy && (req_opcode == nfct4_pkg::OP_CMD) && req_last_byte;

   // Every word carries one to eight bytes.
   `NFCT4_ASSERT_SAME(a_count_range, clock, reset, rsp_strobe, count_legal, "bad byte count")
   // Only the final word of a response may be partly filled.
   `NFCT4_ASSERT_SAME(a_full_words, clock, reset, mid_word, full_count, "short word")
   // The end-of-file notice rides only on the final word of a response.
   `NFCT4_ASSERT_SAME(a_done_last, clock, reset, rsp_record_done, final_word, "stray done")
   // The last byte of a command always starts a response.
   `NFCT4_ASSERT_NEXT(a_cmd_busy, clock, reset, cmd_end, busy, "no response started")

endmodule

@@ tb/nfc_type4_tag_ndef_responder_unit_checker.sv @@
`timescale 1ns / 1ps
module nfc_type4_tag_ndef_responder_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [9:0]  req_load_address,
   input  logic        rsp_strobe,
   input  logic [63:0] rsp_resp_bytes,
   input  logic [3:0]  rsp_byte_count,
   input  logic        rsp_last_word,
   input  logic        rsp_record_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          words_pending
);

   localparam int STORE_DEPTH = 1024;

   typedef struct {
      logic [63:0] resp_bytes;
      logic [3:0]  byte_count;
      logic        last_word;
      logic        record_done;
   } apdu_word_type;

   localparam logic [7:0] CC_IMAGE [15] = '{8'h00, 8'h0F, 8'h20, 8'h00, 8'hFF, 8'h00, 8'hFF,
      8'h04, 8'h06, 8'hE1, 8'h04, 8'h00, 8'hFF, 8'h00, 8'h00};

   apdu_word_type expected_words [$];
   logic [1:0]    sel_mode;
   logic [7:0]    apdu_hdr [12];
   int            hdr_count;
   logic [7:0]    ndef_store [STORE_DEPTH];
   logic [10:0]   ndef_size;

   // Decodes the buffered header and queues the response words it produces.
   task automatic answer_apdu();
      logic [95:0]   hv;
      logic [7:0]    rsp [264];
      int            n, off, len, fsize, pos, words, cnt;
      bit            ok, done;
      apdu_word_type w;
      n = 0; ok = 0; done = 0;
      hv = {apdu_hdr[0], apdu_hdr[1], apdu_hdr[2], apdu_hdr[3], apdu_hdr[4], apdu_hdr[5],
            apdu_hdr[6], apdu_hdr[7], apdu_hdr[8], apdu_hdr[9], apdu_hdr[10], apdu_hdr[11]};
      fsize = (ndef_size > STORE_DEPTH) ? STORE_DEPTH : int'(ndef_size);
      if (hdr_count >= 12 && hv == nfct4_pkg::PAT_APP) begin
         sel_mode = nfct4_pkg::MODE_APP; ok = 1;
      end else if (hdr_count >= 7 && hv[95:40] == nfct4_pkg::PAT_CC) begin
         if (sel_mode == nfct4_pkg::MODE_APP) begin
            sel_mode = nfct4_pkg::MODE_CC; ok = 1;
         end
      end else if (hdr_count >= 7 && hv[95:40] == nfct4_pkg::PAT_NDEF) begin
         sel_mode = nfct4_pkg::MODE_NDEF; ok = 1;
      end else if (hdr_count >= 2 && hv[95:80] == nfct4_pkg::PAT_READ) begin
         if (sel_mode == nfct4_pkg::MODE_CC) begin
            for (int i = 0; i < 15; i++) rsp[i] = CC_IMAGE[i];
            n = 15; ok = 1;
         end else if (sel_mode == nfct4_pkg::MODE_NDEF) begin
            off = {apdu_hdr[2], apdu_hdr[3]};
            len = apdu_hdr[4];
            if (off + len <= fsize + 2) begin
               for (int i = 0; i < len; i++) begin
                  pos = off + i;
                  if (pos == 0) rsp[i] = fsize[15:8];
                  else if (pos == 1) rsp[i] = fsize[7:0];
                  else if (pos - 2 < STORE_DEPTH) rsp[i] = ndef_store[pos - 2];
                  else rsp[i] = 8'h00;
               end
               n = len; ok = 1;
               done = (off + len >= fsize + 2);
            end
         end
      end else if (hdr_count >= 4 && hv[95:64] == nfct4_pkg::PAT_SEL) begin
         ok = 1;
      end
      if (ok) begin
         rsp[n] = nfct4_pkg::SW_OK[15:8]; rsp[n+1] = nfct4_pkg::SW_OK[7:0];
      end else begin
         n = 0; done = 0; sel_mode = nfct4_pkg::MODE_READY;
         rsp[0] = nfct4_pkg::SW_FAIL[15:8]; rsp[1] = nfct4_pkg::SW_FAIL[7:0];
      end
      n += 2;
      for (int i = 0; i < 12; i++) apdu_hdr[i] = 8'h00;
      hdr_count = 0;
      words = (n + 7) / 8;
      for (int k = 0; k < words; k++) begin
         cnt = (n - k * 8 > 8) ? 8 : n - k * 8;
         w.resp_bytes = '0;
         for (int i = 0; i < cnt; i++) w.resp_bytes[63 - 8*i -: 8] = rsp[k*8 + i];
         w.byte_count = cnt[3:0];
         w.last_word = (k + 1 == words);
         w.record_done = (k + 1 == words) && done;
         expected_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      apdu_word_type w;
      if (reset) begin
         expected_words.delete();
         fail_count = 0;
         sel_mode = nfct4_pkg::MODE_READY;
         for (int i = 0; i < 12; i++) apdu_hdr[i] = 8'h00;
         hdr_count = 0;
         ndef_size = '0;
      end else begin
         // Responses always come from earlier transactions, so compare first.
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response word %h count %0d", rsp_resp_bytes,
                           rsp_byte_count);
            end else begin
               w = expected_words.pop_front();
               if (w.resp_bytes !== rsp_resp_bytes || w.byte_count !== rsp_byte_count ||
                   w.last_word !== rsp_last_word || w.record_done !== rsp_record_done) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                              w.resp_bytes, w.byte_count, w.last_word, w.record_done,
                              rsp_resp_bytes, rsp_byte_count, rsp_last_word,
                              rsp_record_done);
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr[2] == nfct4_pkg::CSR_RECORD_SIZE)
            ndef_size = pwdata[10:0];
         if (start && !busy) begin
            case (req_opcode)
               nfct4_pkg::OP_CMD: begin
                  if (hdr_count < 12) begin
                     apdu_hdr[hdr_count] = req_data_byte;
                     hdr_count++;
                  end
                  if (req_last_byte) answer_apdu();
               end
               nfct4_pkg::OP_LOAD: ndef_store[req_load_address] = req_data_byte;
               nfct4_pkg::OP_ACT: begin
                  sel_mode = nfct4_pkg::MODE_READY;
                  for (int i = 0; i < 12; i++) apdu_hdr[i] = 8'h00;
                  hdr_count = 0;
               end
               default: ;
            endcase
         end
      end
      words_pending = expected_words.size();
   end
endmodule

@@ tb/nfc_type4_tag_ndef_responder_unit_tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the type 4 tag responder. The checker beside the
// block predicts every response word; this module only produces transactions,
// record length writes and the final message.
module nfc_type4_tag_ndef_responder_unit_tb;

   // Record store entries written before any read; reads stay inside them.
   localparam int FILL_COUNT = 128;

   logic        clock, reset, start, busy;
   logic [1:0]  req_opcode;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic [9:0]  req_load_address;
   logic        rsp_strobe, rsp_last_word, rsp_record_done;
   logic [63:0] rsp_resp_bytes;
   logic [3:0]  rsp_byte_count;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          fail_count, words_pending;

   // Sender idle percentage of the current phase, and the count of real items.
   int          idle_pct;
   int          item_count;
   int          cur_size;

   nfc_type4_tag_ndef_responder_unit DUT (.*);
   nfc_type4_tag_ndef_responder_unit_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // A hard stop in case the block hangs.
   initial begin
      #40ms;
      $display("nfc_type4_tag_ndef_responder_unit_tb: FAIL");
      $finish;
   end

   // Presents one transaction, optionally after random idle cycles, and returns
   // at the edge where it is taken. The valid stays high into the next item.
   task automatic put_item(input logic [1:0] op, input logic [7:0] b, input logic lst,
                           input logic [9:0] addr);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         req_opcode <= 2'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_data_byte <= b;
      req_last_byte <= lst;
      req_load_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op != nfct4_pkg::OP_NONE) item_count++;
   endtask

   task automatic send_apdu(input logic [7:0] apdu [$]);
      for (int i = 0; i < apdu.size(); i++)
         put_item(nfct4_pkg::OP_CMD, apdu[i], i == apdu.size() - 1, 10'($urandom));
   endtask

   task automatic select_app();
      send_apdu('{8'h00, 8'hA4, 8'h04, 8'h00, 8'h07, 8'hD2, 8'h76, 8'h00, 8'h00, 8'h85,
                  8'h01, 8'h01});
   endtask

   task automatic select_file(input logic [7:0] fid);
      send_apdu('{8'h00, 8'hA4, 8'h00, 8'h0C, 8'h02, 8'hE1, fid});
   endtask

   task automatic read_binary(input logic [15:0] off, input logic [7:0] len);
      send_apdu('{8'h00, 8'hB0, off[15:8], off[7:0], len});
   endtask

   // A read inside the virtual file, usually short so that responses stay small.
   // Reads that return data stay within the filled part of the store; zero-length
   // reads may sit anywhere in the file, its end included.
   task automatic read_inside();
      int vsize, limit, off, len;
      vsize = ((cur_size > 1024) ? 1024 : cur_size) + 2;
      limit = (vsize > FILL_COUNT + 2) ? FILL_COUNT + 2 : vsize;
      if ($urandom_range(0, 7) == 0) begin
         off = $urandom_range(0, 1) ? vsize : $urandom_range(0, vsize);
         read_binary(16'(off), 8'd0);
      end else begin
         off = $urandom_range(0, limit);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
         if (len > limit - off) len = limit - off;
         if ($urandom_range(0, 4) == 0) len = limit - off > 255 ? 255 : limit - off;
         read_binary(16'(off), 8'(len));
      end
   endtask

   // Waits until every response has arrived and the block has gone quiet.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_size(input logic [31:0] v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      cur_size = v[10:0];
   endtask

   task automatic random_sequence();
      int r, n;
      logic [7:0] q [$];
      r = $urandom_range(0, 99);
      if (r < 8) begin
         put_item(nfct4_pkg::OP_ACT, 8'($urandom), 1'($urandom), 10'($urandom));
      end else if (r < 35) begin
         select_app();
         select_file(8'h03);
         read_binary(16'($urandom), 8'($urandom));
      end else if (r < 75) begin
         if ($urandom_range(0, 3) == 0) select_app();
         select_file(8'h04);
         n = $urandom_range(1, 3);
         repeat (n) read_inside();
      end else if (r < 85) begin
         // Noise, often starting like a real header. A noise read gets an offset
         // far past any file so that it never reaches the record store.
         n = $urandom_range(1, 14);
         for (int i = 0; i < n; i++) q.push_back(8'($urandom));
         if ($urandom_range(0, 1)) q[0] = 8'h00;
         if (n > 1 && $urandom_range(0, 1)) q[1] = ($urandom_range(0, 1)) ? 8'hA4 : 8'hB0;
         if (n > 2 && q[0] == 8'h00 && q[1] == 8'hB0) q[2] = 8'hFF;
         send_apdu(q);
      end else if (r < 90) begin
         n = $urandom_range(1, 4);
         repeat (n) put_item(nfct4_pkg::OP_LOAD, 8'($urandom), 1'($urandom), 10'($urandom));
      end else if (r < 94) begin
         put_item(nfct4_pkg::OP_NONE, 8'($urandom), 1'($urandom), 10'($urandom));
      end else begin
         // A broken selection: a truncated or corrupted application select.
         q = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h07, 8'hD2, 8'h76, 8'h00, 8'h00, 8'h85,
               8'h01, 8'h01};
         n = $urandom_range(1, 12);
         while (q.size() > n) void'(q.pop_back());
         if ($urandom_range(0, 1)) q[$urandom_range(0, n - 1)] ^= 8'($urandom_range(1, 255));
         send_apdu(q);
      end
   endtask

   initial begin
      logic [31:0] sizes [4];
      int          base;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = nfct4_pkg::OP_NONE; req_data_byte = '0; req_last_byte = 1'b0;
      req_load_address = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      idle_pct = 0; item_count = 0; cur_size = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the front of the record store; no read ever touches an unwritten entry.
      for (int a = 0; a < FILL_COUNT; a++)
         put_item(nfct4_pkg::OP_LOAD, 8'($urandom), 1'($urandom), 10'(a));
      drain();
      write_size(32'd20);

      // Directed part.
      send_apdu('{8'h00, 8'hB0, 8'h00, 8'h00, 8'h04});     // read while ready
      select_file(8'h03);                                 // CC select outside the application
      select_app();
      select_file(8'h03);
      read_binary(16'hFFFF, 8'hFF);                       // CC read ignores offset and length
      select_file(8'h04);
      read_binary(16'd0, 8'd0);                           // zero length
      read_binary(16'd0, 8'd22);                          // whole file, reaches the end
      read_binary(16'd20, 8'd3);                          // one past the end
      select_file(8'h04);
      send_apdu('{8'h00});                                // short command
      send_apdu('{8'h00, 8'hA4, 8'h04, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                  8'h07, 8'h08, 8'h09, 8'h0A});           // long plain select
      put_item(nfct4_pkg::OP_CMD, 8'h00, 1'b0, 10'h3FF);
      put_item(nfct4_pkg::OP_ACT, 8'hFF, 1'b1, 10'h3FF);  // activation drops partial command
      put_item(nfct4_pkg::OP_NONE, 8'hFF, 1'b1, 10'h3FF);
      put_item(nfct4_pkg::OP_LOAD, 8'hFF, 1'b1, 10'h3FF);
      send_apdu('{8'h00, 8'hB0});                         // read with missing header bytes

      // Random part in phases, with the record length changed between them.
      sizes = '{32'hFFFF_F800 | 32'd1024, 32'd0, 32'h0000_07FF, 32'($urandom_range(1, 300))};
      base = item_count;
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_size(sizes[ph]);
         idle_pct = (ph == 1) ? 58 : (ph == 3) ? 35 : 0;
         while (item_count < base + 57 * (ph + 1)) random_sequence();
      end

      drain();
      if (fail_count == 0 && words_pending == 0)
         $display("nfc_type4_tag_ndef_responder_unit_tb: PASS");
      else
         $display("nfc_type4_tag_ndef_responder_unit_tb: FAIL");
      $finish;
   end
endmodule
